[sv/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define HDTK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, written as antecedent and consequent.
`define HDTK_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    `HDTK_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

[sv/hdtk_pkg.sv]
package hdtk_pkg;

    // default sizing
    localparam int HDTK_NUM_BINS   = 16;
    localparam int HDTK_BIN_SIZE   = 16;
    localparam int HDTK_TOP_K      = 16;
    localparam int HDTK_MAX_SONGS  = 1024;
    localparam int HDTK_COUNT_BITS = 12;

    // fixed field widths
    localparam int DIST_BITS   = 28;
    localparam int ID_OUT_BITS = 10;
    localparam int RC_BITS     = 5;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    // action codes
    localparam logic [2:0] ACT_QUERY_NOTE = 3'd0;
    localparam logic [2:0] ACT_CAND_NOTE  = 3'd1;
    localparam logic [2:0] ACT_FINISH     = 3'd2;
    localparam logic [2:0] ACT_REPORT     = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    // register index (word address bit)
    localparam logic [0:0] REG_RESULT_COUNT = 1'b0;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] note_value;
    } cmd_item_t;

    typedef struct packed {
        logic [ID_OUT_BITS-1:0] song_id;
        logic [DIST_BITS-1:0]   distance_sq;
        logic                   is_valid;
        logic                   last_of_run;
    } res_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dist_stat_t;

endpackage

[sv/hdtk_dist.sv]
// Squared histogram distance, one bin per cycle: |a-b|, square, saturating sum.
module hdtk_dist #(
    parameter int NUM_BINS   = hdtk_pkg::HDTK_NUM_BINS,
    parameter int COUNT_BITS = hdtk_pkg::HDTK_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [COUNT_BITS-1:0]         cand_count,
    input  logic [COUNT_BITS-1:0]         query_count,
    output logic [$clog2(NUM_BINS)-1:0]   bin,
    output hdtk_pkg::dist_stat_t          stat,
    output logic [hdtk_pkg::DIST_BITS-1:0] dist_sum
);
    import hdtk_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int SQ_W  = 2 * COUNT_BITS;
    localparam int SUM_W = ((SQ_W > DIST_BITS) ? SQ_W : DIST_BITS) + 1;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    logic                  run_reg, run_next;
    logic [BIN_W-1:0]      idx_reg, idx_next;
    logic                  sq_vld_reg, sq_vld_next;
    logic                  sq_last_reg, sq_last_next;
    logic                  done_reg, done_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [DIST_BITS-1:0]  sum_reg, sum_next;

    logic [COUNT_BITS-1:0] diff;
    logic [SUM_W-1:0]      sum_wide;

    always_comb
    begin
        diff     = (cand_count > query_count) ? (cand_count - query_count)
                                              : (query_count - cand_count);
        sum_wide = SUM_W'(sum_reg) + SUM_W'(sq_reg);

        run_next     = run_reg;
        idx_next     = idx_reg;
        sq_vld_next  = run_reg;
        sq_last_next = run_reg && (idx_reg == LAST_BIN);
        sq_next      = diff * diff;
        sum_next     = sum_reg;
        done_next    = 1'b0;

        if (sq_vld_reg)
        begin
            sum_next  = (sum_wide > SUM_W'(DIST_MAX)) ? DIST_MAX : sum_wide[DIST_BITS-1:0];
            done_next = sq_last_reg;
        end

        if (start)
        begin
            run_next = 1'b1;
            idx_next = '0;
            sum_next = '0;
        end
        else if (run_reg)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LAST_BIN)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            idx_reg     <= '0;
            sq_vld_reg  <= 1'b0;
            sq_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            run_reg     <= run_next;
            idx_reg     <= idx_next;
            sq_vld_reg  <= sq_vld_next;
            sq_last_reg <= sq_last_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg  <= sq_next;
        sum_reg <= sum_next;
    end

    assign bin       = idx_reg;
    assign stat.busy = run_reg | sq_vld_reg;
    assign stat.done = done_reg;
    assign dist_sum  = sum_reg;

endmodule

[sv/histogram_distance_top_k.sv]
// Histogram distance top-K ranker.
// cmd channel (valid/stall) takes one item per command: query note, candidate
// note, finish candidate, report, clear. res channel (valid/stall) carries the
// ranked results of a report, best first, last_of_run on the final one; an
// empty list reports one item with is_valid low. The user writes result_count
// over APB (word 0) only while the block is idle; the block does not enforce it.
// Steps per item, from acceptance to the next acceptance:
//   note, clear, unused action: accept, update one bin.
//   finish: the distance unit (one bin per cycle through a
//     shared abs/square/accumulate datapath), then the insertion walk
//     (one compare and one ranked-memory move per cycle).
//   report: per result, a memory read, then an output register load;
//     an empty list loads its one marker item directly.
// With res free, a report's first result passes through EXEC, REP_RD, REP_OUT.
// A stalled result holds in the output register; a report in progress waits,
// and intake stays stalled until its last item is loaded. Other commands are
// taken while the final result still waits.
// Reset clears histograms, ranked fill and candidate count; result_count = 1.
`include "assert_macros.svh"

module histogram_distance_top_k #(
    parameter int NUM_BINS   = hdtk_pkg::HDTK_NUM_BINS,
    parameter int BIN_SIZE   = hdtk_pkg::HDTK_BIN_SIZE,
    parameter int TOP_K      = hdtk_pkg::HDTK_TOP_K,
    parameter int MAX_SONGS  = hdtk_pkg::HDTK_MAX_SONGS,
    parameter int COUNT_BITS = hdtk_pkg::HDTK_COUNT_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // commands
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  hdtk_pkg::cmd_item_t   cmd,
    // results
    output logic                  res_valid,
    input  logic                  res_stall,
    output hdtk_pkg::res_item_t   res
);
    import hdtk_pkg::*;

    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int RANK_AW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int FILL_W  = $clog2(TOP_K + 1);
    localparam int ID_BITS = $clog2(MAX_SONGS);
    localparam int SEEN_W  = $clog2(MAX_SONGS + 1);
    localparam int N_W     = (FILL_W > RC_BITS) ? FILL_W : RC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_DIST     = 3'd2;
    localparam logic [2:0] S_INS_CMP  = 3'd3;
    localparam logic [2:0] S_INS_PUT  = 3'd4;
    localparam logic [2:0] S_REP_RD   = 3'd5;
    localparam logic [2:0] S_REP_OUT  = 3'd6;
    localparam logic [2:0] S_REP_NONE = 3'd7;

    // note value -> bin, worked out at elaboration
    logic [7:0] bin_lut [256];
    for (genvar v = 0; v < 256; v++)
    begin : g_bin_lut
        localparam logic [7:0] BIN_OF_V = 8'(v / BIN_SIZE);
        assign bin_lut[v] = BIN_OF_V;
    end

    // control and state
    logic [2:0]             state_reg, state_next;
    logic [COUNT_BITS-1:0]  qh_reg [NUM_BINS];
    logic [COUNT_BITS-1:0]  qh_next [NUM_BINS];
    logic [COUNT_BITS-1:0]  ch_reg [NUM_BINS];
    logic [COUNT_BITS-1:0]  ch_next [NUM_BINS];
    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [RC_BITS-1:0]     rc_reg, rc_next;
    logic                   tail_reg, tail_next;
    logic                   res_valid_reg, res_valid_next;

    // payload
    cmd_item_t              cmd_reg, cmd_next;
    logic [DIST_BITS-1:0]   new_dist_reg, new_dist_next;
    logic [ID_BITS-1:0]     new_id_reg, new_id_next;
    logic [RANK_AW-1:0]     pos_reg, pos_next;
    logic [N_W-1:0]         k_reg, k_next;
    logic [N_W-1:0]         n_reg, n_next;
    res_item_t              res_reg, res_next;

    // ranked list memory
    logic [DIST_BITS-1:0]   dist_mem [TOP_K];
    logic [ID_BITS-1:0]     id_mem [TOP_K];
    logic [DIST_BITS-1:0]   rd_dist_reg;
    logic [ID_BITS-1:0]     rd_id_reg;
    logic                   mem_we;
    logic [RANK_AW-1:0]     mem_waddr;
    logic [DIST_BITS-1:0]   mem_wdist;
    logic [ID_BITS-1:0]     mem_wid;
    logic                   rd_en;
    logic [RANK_AW-1:0]     rd_addr;

    // distance unit
    logic                   dist_start;
    logic [BIN_W-1:0]       dist_bin;
    dist_stat_t             dist_stat;
    logic [DIST_BITS-1:0]   dist_val;

    logic [7:0]             note_bin;
    logic                   note_bin_ok;
    logic [BIN_W-1:0]       hist_addr;
    logic [COUNT_BITS-1:0]  q_rd;
    logic [COUNT_BITS-1:0]  c_rd;
    logic                   res_free;
    logic                   cfg_we;
    logic                   cfg_hit;
    logic [N_W-1:0]         rc_eff;
    logic                   rep_last;

    hdtk_dist #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (dist_start),
        .cand_count  (c_rd),
        .query_count (q_rd),
        .bin         (dist_bin),
        .stat        (dist_stat),
        .dist_sum    (dist_val)
    );

    // APB: single register, always ready
    assign cfg_hit = (paddr[2:2] == REG_RESULT_COUNT);
    assign cfg_we  = psel && penable && pwrite && cfg_hit;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? 32'(rc_reg) : '0;

    // one histogram read port, shared by note updates and the distance walk
    assign note_bin    = bin_lut[cmd_reg.note_value];
    assign note_bin_ok = (note_bin < 8'(NUM_BINS));
    assign hist_addr   = (state_reg == S_DIST) ? dist_bin : note_bin[BIN_W-1:0];
    assign q_rd        = qh_reg[hist_addr];
    assign c_rd        = ch_reg[hist_addr];

    assign res_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign rc_eff   = (rc_reg == '0) ? N_W'(1) : N_W'(rc_reg);
    assign rep_last = ((k_reg + 1'b1) == n_reg);

    always_comb
    begin
        state_next     = state_reg;
        qh_next        = qh_reg;
        ch_next        = ch_reg;
        seen_next      = seen_reg;
        fill_next      = fill_reg;
        rc_next        = cfg_we ? pwdata[RC_BITS-1:0] : rc_reg;
        tail_next      = tail_reg;
        res_valid_next = res_valid_reg && res_stall;
        cmd_next       = cmd_reg;
        new_dist_next  = new_dist_reg;
        new_id_next    = new_id_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdist      = new_dist_reg;
        mem_wid        = new_id_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        dist_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                case (cmd_reg.action)
                    ACT_QUERY_NOTE:
                    begin
                        if (note_bin_ok && (q_rd != COUNT_MAX))
                        begin
                            qh_next[note_bin[BIN_W-1:0]] = q_rd + 1'b1;
                        end
                    end
                    ACT_CAND_NOTE:
                    begin
                        if (note_bin_ok && (c_rd != COUNT_MAX))
                        begin
                            ch_next[note_bin[BIN_W-1:0]] = c_rd + 1'b1;
                        end
                    end
                    ACT_FINISH:
                    begin
                        dist_start = 1'b1;
                        state_next = S_DIST;
                    end
                    ACT_REPORT:
                    begin
                        k_next = '0;
                        n_next = (rc_eff > N_W'(fill_reg)) ? N_W'(fill_reg) : rc_eff;
                        state_next = (fill_reg == '0) ? S_REP_NONE : S_REP_RD;
                    end
                    ACT_CLEAR:
                    begin
                        qh_next   = '{default: '0};
                        ch_next   = '{default: '0};
                        seen_next = '0;
                        fill_next = '0;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_DIST:
            begin
                if (dist_stat.done)
                begin
                    ch_next = '{default: '0};
                    if (seen_reg == SEEN_W'(MAX_SONGS))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        new_dist_next = dist_val;
                        new_id_next   = seen_reg[ID_BITS-1:0];
                        seen_next     = seen_reg + 1'b1;
                        if (fill_reg == FILL_W'(TOP_K))
                        begin
                            // full list: the tail must be beaten first
                            tail_next  = 1'b1;
                            pos_next   = RANK_AW'(TOP_K - 1);
                            rd_en      = 1'b1;
                            rd_addr    = RANK_AW'(TOP_K - 1);
                            state_next = S_INS_CMP;
                        end
                        else if (fill_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            tail_next  = 1'b0;
                            pos_next   = RANK_AW'(fill_reg);
                            rd_en      = 1'b1;
                            rd_addr    = RANK_AW'(fill_reg - 1'b1);
                            state_next = S_INS_CMP;
                        end
                    end
                end
            end

            S_INS_CMP:
            begin
                // rd data holds the entry just above pos (or the tail itself)
                if (rd_dist_reg > new_dist_reg)
                begin
                    if (tail_reg)
                    begin
                        tail_next = 1'b0;
                        if (pos_reg == '0)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = pos_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg;
                        mem_wdist = rd_dist_reg;
                        mem_wid   = rd_id_reg;
                        pos_next  = pos_reg - 1'b1;
                        if (pos_reg == RANK_AW'(1))
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = pos_reg - RANK_AW'(2);
                        end
                    end
                end
                else
                begin
                    // equal distance keeps the older id first
                    state_next = tail_reg ? S_IDLE : S_INS_PUT;
                    tail_next  = 1'b0;
                end
            end

            S_INS_PUT:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                if (fill_reg != FILL_W'(TOP_K))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = S_IDLE;
            end

            S_REP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg[RANK_AW-1:0];
                state_next = S_REP_OUT;
            end

            S_REP_OUT:
            begin
                if (res_free)
                begin
                    res_next.song_id     = ID_OUT_BITS'(rd_id_reg);
                    res_next.distance_sq = rd_dist_reg;
                    res_next.is_valid    = 1'b1;
                    res_next.last_of_run = rep_last;
                    res_valid_next       = 1'b1;
                    k_next               = k_reg + 1'b1;
                    state_next           = rep_last ? S_IDLE : S_REP_RD;
                end
            end

            S_REP_NONE:
            begin
                if (res_free)
                begin
                    res_next.song_id     = '0;
                    res_next.distance_sq = '0;
                    res_next.is_valid    = 1'b0;
                    res_next.last_of_run = 1'b1;
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            qh_reg        <= '{default: '0};
            ch_reg        <= '{default: '0};
            seen_reg      <= '0;
            fill_reg      <= '0;
            rc_reg        <= RC_BITS'(1);
            tail_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            qh_reg        <= qh_next;
            ch_reg        <= ch_next;
            seen_reg      <= seen_next;
            fill_reg      <= fill_next;
            rc_reg        <= rc_next;
            tail_reg      <= tail_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        new_dist_reg <= new_dist_next;
        new_id_reg   <= new_id_next;
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        res_reg      <= res_next;
    end

    // ranked list: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dist_mem[mem_waddr] <= mem_wdist;
            id_mem[mem_waddr]   <= mem_wid;
        end
        if (rd_en)
        begin
            rd_dist_reg <= dist_mem[rd_addr];
            rd_id_reg   <= id_mem[rd_addr];
        end
    end

    `HDTK_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(TOP_K), "ranked fill above TOP_K")
    `HDTK_ASSERT(a_seen_bound, clk, rst_n, seen_reg <= SEEN_W'(MAX_SONGS), "candidate count overrun")
    `HDTK_ASSERT_IMPLY(a_dist_stalls, clk, rst_n, dist_stat.busy, cmd_stall, "intake open during distance walk")
    `HDTK_ASSERT_IMPLY(a_empty_last, clk, rst_n, res_valid && !res.is_valid, res.last_of_run, "empty report item not last")

endmodule

[verif/histogram_distance_top_k_test.sv]
module histogram_distance_top_k_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hdtk_pkg::*;

    // Unused action codes: the block must take them and do nothing.
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    // Byte address of the result_count register (word index 0).
    localparam logic [2:0] RESULT_COUNT_ADDR = {REG_RESULT_COUNT, 2'b00};

    // A finish can run the distance walk and then the insertion walk with no
    // result to show for it; wait this long before touching the register or
    // ending the run.
    localparam int SETTLE_CYCLES = HDTK_NUM_BINS + HDTK_TOP_K + 16;

    // Items in the random traffic phase.
    localparam int RANDOM_ITEMS = 380;

    // ------------------------------------------------------------------
    // Clock, reset, block ports
    // ------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_item_t   cmd       = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_item_t   res;

    always #5 clk = ~clk;

    histogram_distance_top_k u_dut (.*);

    // ------------------------------------------------------------------
    // Ranker prediction: histograms, ranked list, report length
    // ------------------------------------------------------------------
    logic [HDTK_COUNT_BITS-1:0] query_hist [HDTK_NUM_BINS];
    logic [HDTK_COUNT_BITS-1:0] cand_hist  [HDTK_NUM_BINS];
    int unsigned                songs_ranked;   // candidates accepted so far
    logic [DIST_BITS-1:0]       rank_dist  [HDTK_TOP_K];
    int unsigned                rank_id    [HDTK_TOP_K];
    int unsigned                rank_fill;
    logic [RC_BITS-1:0]         report_len;

    // Results owed by the block, oldest first.
    res_item_t pending_results [$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    int  hold_left      = 0;    // receiver hold-off, in cycles

    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatch_count < 10)
            $display("%0t mismatch %s: expected %0d (0x%0h) got %0d (0x%0h)",
                     $realtime, what, want, want, got, got);
        mismatch_count++;
    endfunction

    function automatic void clear_ranker();
        foreach (query_hist[i]) query_hist[i] = '0;
        foreach (cand_hist[i]) cand_hist[i] = '0;
        foreach (rank_dist[i]) rank_dist[i] = '0;
        foreach (rank_id[i]) rank_id[i] = 0;
        songs_ranked = 0;
        rank_fill    = 0;
    endfunction

    // Bin one note; out-of-range bins are dropped, counts stick at all-ones.
    function automatic void add_note(bit to_query, logic [7:0] value);
        int unsigned bin;
        bin = value / HDTK_BIN_SIZE;
        if (bin >= HDTK_NUM_BINS)
            return;
        if (to_query) begin
            if (query_hist[bin] != '1)
                query_hist[bin]++;
        end
        else if (cand_hist[bin] != '1) begin
            cand_hist[bin]++;
        end
    endfunction

    // Squared distance, clamped at DIST_MAX after every bin.
    function automatic logic [DIST_BITS-1:0] histogram_distance();
        longint sum;
        longint d;
        sum = 0;
        for (int i = 0; i < HDTK_NUM_BINS; i++) begin
            d   = longint'(cand_hist[i]) - longint'(query_hist[i]);
            sum += d * d;
            if (sum > longint'(DIST_MAX))
                sum = longint'(DIST_MAX);
        end
        return sum[DIST_BITS-1:0];
    endfunction

    // New id is always the largest, so it lands after equal distances.
    function automatic void insert_ranked(logic [DIST_BITS-1:0] new_dist, int unsigned id);
        int unsigned pos;
        int unsigned i;
        pos = 0;
        while (pos < rank_fill && rank_dist[pos] <= new_dist)
            pos++;
        if (pos >= HDTK_TOP_K)
            return;
        i = (rank_fill < HDTK_TOP_K) ? rank_fill : HDTK_TOP_K - 1;
        while (i > pos) begin
            rank_dist[i] = rank_dist[i - 1];
            rank_id[i]   = rank_id[i - 1];
            i--;
        end
        rank_dist[pos] = new_dist;
        rank_id[pos]   = id;
        if (rank_fill < HDTK_TOP_K)
            rank_fill++;
    endfunction

    function automatic void apply_command(cmd_item_t it);
        res_item_t   r;
        int unsigned n;
        case (it.action)
            ACT_QUERY_NOTE: add_note(1'b1, it.note_value);
            ACT_CAND_NOTE:  add_note(1'b0, it.note_value);
            ACT_FINISH:
            begin
                // past MAX_SONGS a finish only empties the candidate
                if (songs_ranked < HDTK_MAX_SONGS) begin
                    insert_ranked(histogram_distance(), songs_ranked);
                    songs_ranked++;
                end
                foreach (cand_hist[i]) cand_hist[i] = '0;
            end
            ACT_REPORT:
            begin
                if (rank_fill == 0) begin
                    // empty list: one invalid marker item
                    r             = '0;
                    r.last_of_run = 1'b1;
                    pending_results.push_back(r);
                end
                else begin
                    n = (report_len == 0) ? 1 : report_len;
                    if (n > rank_fill)
                        n = rank_fill;
                    for (int unsigned k = 0; k < n; k++) begin
                        r.song_id     = ID_OUT_BITS'(rank_id[k]);
                        r.distance_sq = rank_dist[k];
                        r.is_valid    = 1'b1;
                        r.last_of_run = (k + 1 == n);
                        pending_results.push_back(r);
                    end
                end
            end
            ACT_CLEAR: clear_ranker();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall generation and checking
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result, song_id", '0, res.song_id);
            end
            else begin
                want = pending_results.pop_front();
                if (res.song_id !== want.song_id)
                    flag_mismatch("song_id", want.song_id, res.song_id);
                if (res.distance_sq !== want.distance_sq)
                    flag_mismatch("distance_sq", want.distance_sq, res.distance_sq);
                if (res.is_valid !== want.is_valid)
                    flag_mismatch("is_valid", want.is_valid, res.is_valid);
                if (res.last_of_run !== want.last_of_run)
                    flag_mismatch("last_of_run", want.last_of_run, res.last_of_run);
            end
        end
        // long hold-off first, else random ~10% stall
        if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else begin
            res_stall <= rx_idle_on && ($urandom_range(99) < 10);
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offer one item, hold it until taken, then predict. Valid stays high on
    // return so the next item can follow back to back.
    task automatic send_item(logic [2:0] action, logic [7:0] note);
        cmd_item_t it;
        it.action     = action;
        it.note_value = note;
        while (tx_idle_on && $urandom_range(99) < 10) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        apply_command(it);
        items_sent++;
    endtask

    // Stop offering, wait for every owed result, then let a finish in
    // flight run out.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write, then read back. Only called with the block idle.
    task automatic write_result_count(logic [RC_BITS-1:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RESULT_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        report_len = value;
        // back-to-back read: new setup phase with psel held
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[RC_BITS-1:0] !== value)
            flag_mismatch("result_count readback", 32'(value), readback);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every action, ties, unused codes, empty reports.
    task automatic test_directed();
        send_item(ACT_REPORT, 8'h00);           // empty list, count of one
        drain_results();
        write_result_count(RC_BITS'(16));
        send_item(ACT_QUERY_NOTE, 8'd0);
        send_item(ACT_QUERY_NOTE, 8'd15);
        send_item(ACT_QUERY_NOTE, 8'd16);
        send_item(ACT_QUERY_NOTE, 8'd255);
        send_item(ACT_CAND_NOTE, 8'd0);
        send_item(ACT_CAND_NOTE, 8'd128);
        send_item(ACT_CAND_NOTE, 8'd255);
        send_item(ACT_FINISH, 8'hFF);           // id 0
        send_item(ACT_FINISH, 8'h00);           // empty candidate, id 1
        send_item(ACT_CAND_NOTE, 8'd0);
        send_item(ACT_CAND_NOTE, 8'd100);
        send_item(ACT_CAND_NOTE, 8'd255);
        send_item(ACT_FINISH, 8'h55);           // ties id 0 on distance
        send_item(ACT_CAND_NOTE, 8'd0);
        send_item(ACT_CAND_NOTE, 8'd1);
        send_item(ACT_CAND_NOTE, 8'd31);
        send_item(ACT_CAND_NOTE, 8'd240);
        send_item(ACT_FINISH, 8'hAA);           // exact match, ranks first
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            send_item(3'(a), 8'hA5);
        send_item(ACT_REPORT, 8'hFF);
        send_item(ACT_CLEAR, 8'h00);
        send_item(ACT_REPORT, 8'h5A);           // empty after clear
        drain_results();
    endtask

    // Count of zero acts as one; counts above the fill stop at the fill.
    task automatic test_report_length();
        logic [RC_BITS-1:0] lengths [4] = '{'0, '1, RC_BITS'(2), RC_BITS'(1)};
        send_item(ACT_CLEAR, 8'h00);
        repeat (3) begin
            repeat ($urandom_range(1, 6))
                send_item(ACT_CAND_NOTE, 8'($urandom));
            send_item(ACT_FINISH, 8'($urandom));
        end
        foreach (lengths[i]) begin
            drain_results();
            write_result_count(lengths[i]);
            send_item(ACT_REPORT, 8'($urandom));
        end
        drain_results();
    endtask

    // Receiver holds off for a long stretch while reports and notes keep
    // coming, so the result register fills and intake stalls.
    task automatic test_backpressure();
        write_result_count(RC_BITS'(16));
        send_item(ACT_CLEAR, 8'h00);
        repeat (20) begin
            repeat ($urandom_range(0, 4))
                send_item(ACT_CAND_NOTE, 8'($urandom));
            send_item(ACT_FINISH, 8'($urandom));
        end
        hold_left = 400;
        repeat (3) begin
            send_item(ACT_REPORT, 8'($urandom));
            repeat (4) send_item(ACT_QUERY_NOTE, 8'($urandom));
        end
        drain_results();
    endtask

    // Mostly well-formed traffic: queries, candidates with finish, reports;
    // some clears, register changes and random noise. One long stretch
    // runs with no idling on either side.
    task automatic test_random_traffic();
        int stop_at;
        int quiet_from;
        stop_at    = items_sent + RANDOM_ITEMS;
        quiet_from = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < stop_at) begin
            tx_idle_on = !(items_sent >= quiet_from && items_sent < quiet_from + 120);
            rx_idle_on = tx_idle_on;
            case ($urandom_range(11))
                0: send_item(ACT_CLEAR, 8'($urandom));
                1: repeat ($urandom_range(1, 3))
                       send_item(3'($urandom_range(7)), 8'($urandom));
                2:
                begin
                    drain_results();
                    write_result_count(RC_BITS'($urandom_range(31)));
                end
                3, 4: repeat ($urandom_range(1, 6))
                          send_item(ACT_QUERY_NOTE, 8'($urandom));
                default:
                begin
                    repeat ($urandom_range(1, 4)) begin
                        // low notes crowd a few bins, so near ties are common
                        repeat ($urandom_range(0, 8))
                            send_item(ACT_CAND_NOTE, $urandom_range(1) ?
                                      8'($urandom_range(63)) : 8'($urandom));
                        send_item(ACT_FINISH, 8'($urandom));
                    end
                    if ($urandom_range(1))
                        send_item(ACT_REPORT, 8'($urandom));
                end
            endcase
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_item(ACT_REPORT, 8'($urandom));
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_ranker();
        report_len = RC_BITS'(1);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_report_length();
        test_backpressure();
        test_random_traffic();

        // drain_results already waited out the tail latency
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hang guard: several times the slowest expected run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
